>>> rtl/fbwd_pkg.sv
// Package for the frame black/white detector: pixel and result beat types,
// register indexes and the reset values of the limits and extremes.
// Depends on nothing; every other file of the block imports it.
package fbwd_pkg;

    localparam int CHAN_W = 8;

    typedef logic [CHAN_W-1:0] t_chan;

    localparam t_chan BLACK_LIMIT_RESET = t_chan'(32);
    localparam t_chan WHITE_LIMIT_RESET = t_chan'(224);
    localparam t_chan CHAN_MAX          = t_chan'(255);
    localparam t_chan CHAN_MIN          = t_chan'(0);

    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BLACK_LIMIT = 1'b0;
    localparam t_cfg_idx CFG_WHITE_LIMIT = 1'b1;

    typedef struct packed {
        t_chan blue;
        t_chan green;
        t_chan red;
        logic  frame_last;
    } t_pixel;

    typedef struct packed {
        logic frame_is_black;
        logic frame_is_white;
        logic black_began;
        logic black_ended;
        logic white_began;
        logic white_ended;
    } t_result;

    typedef struct packed {
        t_chan lo;
        t_chan hi;
    } t_extremes;

endpackage

>>> rtl/fbwd_pixel_if.sv
// Pixel stream channel: valid/ready handshake carrying one pixel per beat.
// Depends on fbwd_pkg.
interface fbwd_pixel_if;
    import fbwd_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/fbwd_result_if.sv
// Result channel: valid/ready handshake carrying one frame verdict per beat.
// Depends on fbwd_pkg.
interface fbwd_result_if;
    import fbwd_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/fbwd_track.sv
// Running minimum and maximum of one colour channel over a frame.
// Depends on fbwd_pkg.
module fbwd_track (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_clear,
    input  fbwd_pkg::t_chan    i_value,
    output fbwd_pkg::t_extremes o_ext
);
    import fbwd_pkg::*;

    t_chan r_lo;
    t_chan r_hi;
    t_chan n_lo;
    t_chan n_hi;

    always_comb begin
        n_lo = (i_value < r_lo) ? i_value : r_lo;
        n_hi = (i_value > r_hi) ? i_value : r_hi;
    end

    assign o_ext.lo = n_lo;
    assign o_ext.hi = n_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= CHAN_MAX;
            r_hi <= CHAN_MIN;
        end else if (i_step) begin
            if (i_clear) begin
                r_lo <= CHAN_MAX;
                r_hi <= CHAN_MIN;
            end else begin
                r_lo <= n_lo;
                r_hi <= n_hi;
            end
        end
    end

endmodule

>>> rtl/frame_black_white_detector_top.sv
// Frame black/white detector top level: input register, three channel trackers
// and the result register. Depends on fbwd_pkg, fbwd_pixel_if, fbwd_result_if
// and fbwd_track.
// Throughput is one pixel per cycle, except that a frame's last pixel waits
// in the input register while the previous result is stalled. The input and
// result registers are the only stages; the result loads as the last pixel leaves.
// Reset clears the extremes, the previous-frame flags and both valid bits and
// loads the limits with 32 and 224.
module frame_black_white_detector_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fbwd_pixel_if.sink          i_pix,
    fbwd_result_if.source       o_res,
    input  logic                i_cfg_we,
    input  fbwd_pkg::t_cfg_idx  i_cfg_idx,
    input  fbwd_pkg::t_chan     i_cfg_data
);
    import fbwd_pkg::*;

    t_chan     r_black_limit;
    t_chan     r_white_limit;
    logic      r_in_valid;
    t_pixel    r_in;
    logic      r_res_valid;
    t_result   r_res;
    logic      r_was_black;
    logic      r_was_white;

    logic      w_out_free;
    logic      w_consume;
    logic      w_load;
    logic      w_blk;
    logic      w_wht;
    t_extremes w_red;
    t_extremes w_green;
    t_extremes w_blue;
    t_result   n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_limit <= BLACK_LIMIT_RESET;
            r_white_limit <= WHITE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLACK_LIMIT: r_black_limit <= i_cfg_data;
                CFG_WHITE_LIMIT: r_white_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_res_valid || o_res.ready;
    assign w_consume  = r_in_valid && (!r_in.frame_last || w_out_free);
    assign w_load     = w_consume && r_in.frame_last;
    assign i_pix.ready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_in <= i_pix.data;
        end
    end

    fbwd_track u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_consume),
        .i_clear (r_in.frame_last),
        .i_value (r_in.red),
        .o_ext   (w_red)
    );

    fbwd_track u_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_consume),
        .i_clear (r_in.frame_last),
        .i_value (r_in.green),
        .o_ext   (w_green)
    );

    fbwd_track u_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_consume),
        .i_clear (r_in.frame_last),
        .i_value (r_in.blue),
        .o_ext   (w_blue)
    );

    always_comb begin
        w_blk = (w_red.hi < r_black_limit) && (w_green.hi < r_black_limit)
             && (w_blue.hi < r_black_limit);
        w_wht = (w_red.lo > r_white_limit) && (w_green.lo > r_white_limit)
             && (w_blue.lo > r_white_limit);
        n_res.frame_is_black = w_blk;
        n_res.frame_is_white = w_wht;
        n_res.black_began    = w_blk && !r_was_black;
        n_res.black_ended    = !w_blk && r_was_black;
        n_res.white_began    = w_wht && !r_was_white;
        n_res.white_ended    = !w_wht && r_was_white;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_was_black <= 1'b0;
            r_was_white <= 1'b0;
        end else if (w_load) begin
            r_res_valid <= 1'b1;
            r_was_black <= w_blk;
            r_was_white <= w_wht;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    a_load_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_res_valid)
        else $error("Last pixel consumed without a result being loaded.");

    a_flags_follow_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_was_black == r_res.frame_is_black)
                     && (r_was_white == r_res.frame_is_white))
        else $error("Previous-frame flags disagree with the pending result.");

    a_black_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (!r_res.black_began || r_res.frame_is_black)
                     && (!r_res.black_ended || !r_res.frame_is_black))
        else $error("Black edge event contradicts the black flag.");

    a_white_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (!r_res.white_began || r_res.frame_is_white)
                     && (!r_res.white_ended || !r_res.frame_is_white))
        else $error("White edge event contradicts the white flag.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_res.ready) |-> !w_load)
        else $error("Stalled result overwritten.");

endmodule
